[hdl/bmi_pkg.sv]
// types, constants and microcode table for the binary modular inverse
`default_nettype none

package bmi_pkg;

    localparam int FIELD_W  = 64;
    localparam int STATUS_W = 2;
    localparam int UPC_W    = 4;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_OPERAND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_INV     = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_HALVE_U  = 3'd1,
        OP_HALVE_V  = 3'd2,
        OP_SUB      = 3'd3,
        OP_FIX      = 3'd4,
        OP_DONE_OK  = 3'd5,
        OP_DONE_NI  = 3'd6,
        OP_DONE_BAD = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        CND_NEVER  = 3'd0,
        CND_ALWAYS = 3'd1,
        CND_A_BAD  = 3'd2,
        CND_P_EVEN = 3'd3,
        CND_U_EVEN = 3'd4,
        CND_V_EVEN = 3'd5,
        CND_U_NZ   = 3'd6,
        CND_V_NE1  = 3'd7
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic a_bad;
        logic p_even;
        logic u_even;
        logic v_even;
        logic u_nz;
        logic v_ne1;
    } t_flags;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_ctl;

    // microcode labels
    localparam logic [UPC_W-1:0] L_CHK_A   = 4'd0;
    localparam logic [UPC_W-1:0] L_CHK_P   = 4'd1;
    localparam logic [UPC_W-1:0] L_HALVE_U = 4'd2;
    localparam logic [UPC_W-1:0] L_HALVE_V = 4'd3;
    localparam logic [UPC_W-1:0] L_SUB     = 4'd4;
    localparam logic [UPC_W-1:0] L_FIX     = 4'd5;
    localparam logic [UPC_W-1:0] L_CHK_V   = 4'd6;
    localparam logic [UPC_W-1:0] L_OK      = 4'd7;
    localparam logic [UPC_W-1:0] L_NI      = 4'd8;
    localparam logic [UPC_W-1:0] L_BAD     = 4'd9;

    function automatic t_uword urom(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{op: OP_NOP, cond: CND_NEVER, target: L_CHK_A};
        case (addr)
            L_CHK_A:   w = '{op: OP_NOP,      cond: CND_A_BAD,  target: L_BAD};
            L_CHK_P:   w = '{op: OP_NOP,      cond: CND_P_EVEN, target: L_NI};
            L_HALVE_U: w = '{op: OP_HALVE_U,  cond: CND_U_EVEN, target: L_HALVE_U};
            L_HALVE_V: w = '{op: OP_HALVE_V,  cond: CND_V_EVEN, target: L_HALVE_V};
            L_SUB:     w = '{op: OP_SUB,      cond: CND_NEVER,  target: L_CHK_A};
            L_FIX:     w = '{op: OP_FIX,      cond: CND_U_NZ,   target: L_HALVE_U};
            L_CHK_V:   w = '{op: OP_NOP,      cond: CND_V_NE1,  target: L_NI};
            L_OK:      w = '{op: OP_DONE_OK,  cond: CND_NEVER,  target: L_CHK_A};
            L_NI:      w = '{op: OP_DONE_NI,  cond: CND_NEVER,  target: L_CHK_A};
            L_BAD:     w = '{op: OP_DONE_BAD, cond: CND_NEVER,  target: L_CHK_A};
            default:   w = '{op: OP_DONE_BAD, cond: CND_NEVER,  target: L_CHK_A};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/bmi_sequencer.sv]
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module bmi_sequencer import bmi_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_start,
    input  t_flags i_flags,
    output logic   o_busy,
    output t_ctl   o_ctl
);

    logic             r_busy, n_busy;
    logic [UPC_W-1:0] r_pc, n_pc;
    t_uword           word;
    logic             hit;

    assign word = urom(r_pc);

    always_comb begin
        case (word.cond)
            CND_NEVER:  hit = 1'b0;
            CND_ALWAYS: hit = 1'b1;
            CND_A_BAD:  hit = i_flags.a_bad;
            CND_P_EVEN: hit = i_flags.p_even;
            CND_U_EVEN: hit = i_flags.u_even;
            CND_V_EVEN: hit = i_flags.v_even;
            CND_U_NZ:   hit = i_flags.u_nz;
            CND_V_NE1:  hit = i_flags.v_ne1;
            default:    hit = 1'b0;
        endcase
    end

    always_comb begin
        n_busy     = r_busy;
        n_pc       = r_pc;
        o_ctl.load = 1'b0;
        o_ctl.op   = OP_NOP;
        if (!r_busy) begin
            if (i_start) begin
                n_busy     = 1'b1;
                n_pc       = L_CHK_A;
                o_ctl.load = 1'b1;
            end
        end else begin
            o_ctl.op = word.op;
            n_pc     = hit ? word.target : r_pc + UPC_W'(1);
            if (word.op inside {OP_DONE_OK, OP_DONE_NI, OP_DONE_BAD}) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= L_CHK_A;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

[hdl/bmi_datapath.sv]
// working registers, modular half and subtract units, result register
`default_nettype none

module bmi_datapath import bmi_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_ctl                i_ctl,
    input  wire [FIELD_W-1:0]   i_operand,
    input  wire                 i_cfg_we,
    input  wire [FIELD_W-1:0]   i_cfg_data,
    output t_flags              o_flags,
    output logic                o_valid,
    output logic [FIELD_W-1:0]  o_inverse,
    output logic [STATUS_W-1:0] o_status
);

    logic [WIDTH-1:0]    r_p;
    logic [WIDTH-1:0]    r_u, n_u, r_v, n_v, r_x1, n_x1, r_x2, n_x2;
    logic                r_borrow, n_borrow, r_side, n_side;
    logic                r_valid, n_valid;
    logic [WIDTH-1:0]    r_inverse, n_inverse;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                u_ge_v;

    function automatic logic [WIDTH-1:0] half_mod(input logic [WIDTH-1:0] x,
                                                  input logic [WIDTH-1:0] p);
        return x[0] ? (x >> 1) + (p >> 1) + WIDTH'(1) : (x >> 1);
    endfunction

    assign u_ge_v = (r_u >= r_v);

    assign o_flags.a_bad  = (r_u == '0) || u_ge_v;
    assign o_flags.p_even = ~r_v[0];
    assign o_flags.u_even = ~r_u[0];
    assign o_flags.v_even = ~r_v[0];
    assign o_flags.u_nz   = (r_u != '0);
    assign o_flags.v_ne1  = (r_v != WIDTH'(1));

    always_comb begin
        n_u       = r_u;
        n_v       = r_v;
        n_x1      = r_x1;
        n_x2      = r_x2;
        n_borrow  = r_borrow;
        n_side    = r_side;
        n_valid   = 1'b0;
        n_inverse = r_inverse;
        n_status  = r_status;
        if (i_ctl.load) begin
            n_u  = i_operand[WIDTH-1:0];
            n_v  = r_p;
            n_x1 = WIDTH'(1);
            n_x2 = '0;
        end else begin
            case (i_ctl.op)
                OP_HALVE_U: begin
                    if (!r_u[0]) begin
                        n_u  = r_u >> 1;
                        n_x1 = half_mod(r_x1, r_p);
                    end
                end
                OP_HALVE_V: begin
                    if (!r_v[0]) begin
                        n_v  = r_v >> 1;
                        n_x2 = half_mod(r_x2, r_p);
                    end
                end
                OP_SUB: begin
                    // coefficient difference wraps, fixed up on the next step
                    if (u_ge_v) begin
                        n_u      = r_u - r_v;
                        n_x1     = r_x1 - r_x2;
                        n_borrow = (r_x1 < r_x2);
                        n_side   = 1'b0;
                    end else begin
                        n_v      = r_v - r_u;
                        n_x2     = r_x2 - r_x1;
                        n_borrow = (r_x2 < r_x1);
                        n_side   = 1'b1;
                    end
                end
                OP_FIX: begin
                    if (r_borrow) begin
                        if (r_side) begin
                            n_x2 = r_x2 + r_p;
                        end else begin
                            n_x1 = r_x1 + r_p;
                        end
                    end
                end
                OP_DONE_OK: begin
                    n_valid   = 1'b1;
                    n_inverse = r_x2;
                    n_status  = ST_OK;
                end
                OP_DONE_NI: begin
                    n_valid   = 1'b1;
                    n_inverse = '0;
                    n_status  = ST_NOT_INV;
                end
                OP_DONE_BAD: begin
                    n_valid   = 1'b1;
                    n_inverse = '0;
                    n_status  = ST_BAD_OPERAND;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p     <= WIDTH'(3);
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_p <= i_cfg_data[WIDTH-1:0];
            end
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u       <= n_u;
        r_v       <= n_v;
        r_x1      <= n_x1;
        r_x2      <= n_x2;
        r_borrow  <= n_borrow;
        r_side    <= n_side;
        r_inverse <= n_inverse;
        r_status  <= n_status;
    end

    assign o_valid   = r_valid;
    assign o_inverse = FIELD_W'(r_inverse);
    assign o_status  = r_status;

endmodule

`default_nettype wire

[hdl/binary_modular_inverse.sv]
// top level of the binary modular inverse block
// An operand is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with o_valid high, and the receiver cannot stall it, so it
// must capture the result in that cycle. The work runs on a microcoded sequencer that
// issues one datapath step per cycle: each halving of u or v is a single step, each
// subtraction a subtract step followed by a step that adds back the modulus on borrow,
// plus a step to leave each halving loop, two entry checks, a final gcd check and one
// result step. busy drops in the cycle the result shows, so the next operand can be
// taken while it is on the ports. The modulus is written through the configuration
// channel, which is always ready, and must only change while busy is low.
`default_nettype none

module binary_modular_inverse import bmi_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire [FIELD_W-1:0]   i_operand,
    output logic                busy,
    input  wire                 i_cfg_valid,
    input  wire [FIELD_W-1:0]   i_cfg_data,
    output logic                o_cfg_ready,
    output logic                o_valid,
    output logic [FIELD_W-1:0]  o_inverse,
    output logic [STATUS_W-1:0] o_status
);

    t_flags flags;
    t_ctl   ctl;

    assign o_cfg_ready = 1'b1;

    bmi_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    bmi_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_operand  (i_operand),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_flags    (flags),
        .o_valid    (o_valid),
        .o_inverse  (o_inverse),
        .o_status   (o_status)
    );

endmodule

`default_nettype wire

[hdl/bmi_checker.sv]
// port-level checker for the binary modular inverse, bound to the top level
`default_nettype none

module bmi_checker import bmi_pkg::*; (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 o_valid,
    input wire [FIELD_W-1:0]   o_inverse,
    input wire [STATUS_W-1:0]  o_status
);

    // accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // a result only follows a busy cycle
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction in flight");

    // one result per transaction, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // errors carry a zero inverse and a known status
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_inverse == '0 &&
            (o_status == ST_BAD_OPERAND || o_status == ST_NOT_INV)))
        else $error("error result with nonzero inverse or bad status");

endmodule

bind binary_modular_inverse bmi_checker u_bmi_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_inverse (o_inverse),
    .o_status  (o_status)
);

`default_nettype wire
